>>> rtl/cpbs_pkg.sv
package cpbs_pkg;

  localparam int unsigned SyncZeroRun   = 16;
  localparam logic [4:0]  SyncGroupsMax = 5'd16;
  localparam logic [4:0]  SyncGroupsRst = 5'd13;
  localparam logic [6:0]  SyncTail      = 7'h73;
  localparam logic [3:0]  SyncTailLast  = 4'd6;
  localparam logic [3:0]  ByteBitLast   = 4'd7;
  localparam logic [3:0]  ZeroRunLast   = 4'(SyncZeroRun - 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } out_word_t;

  typedef enum logic [2:0] {
    SRC_ONE,
    SRC_ZERO,
    SRC_TAIL,
    SRC_DATA,
    SRC_SUM
  } bit_src_t;

  typedef struct packed {
    logic       load;
    logic       push;
    bit_src_t   src;
    logic [2:0] idx;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic push_ok;
    logic flush_done;
    logic held_valid;
  } status_t;

endpackage

>>> rtl/cpbs_dpath.sv
module cpbs_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpbs_pkg::in_word_t   in_word,
  input  cpbs_pkg::cmd_t       cmd,
  output cpbs_pkg::status_t    st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cpbs_pkg::out_word_t  out_word
);

  logic [7:0] data_r,     data_nxt;
  logic [7:0] sum_r,      sum_nxt;
  logic [6:0] shift_r,    shift_nxt;
  logic [2:0] count_r,    count_nxt;
  logic [7:0] held_r,     held_nxt;
  logic       held_vld_r, held_vld_nxt;
  logic       out_vld_r,  out_vld_nxt;
  cpbs_pkg::out_word_t out_r, out_nxt;

  logic       out_free;
  logic       bit_val;
  logic [7:0] joined;

  assign out_free = !out_vld_r || !out_stall;
  assign joined   = {shift_r, bit_val};

  always_comb begin
    case (cmd.src)
      cpbs_pkg::SRC_ONE:  bit_val = 1'b1;
      cpbs_pkg::SRC_ZERO: bit_val = 1'b0;
      cpbs_pkg::SRC_TAIL: bit_val = cpbs_pkg::SyncTail[cmd.idx];
      cpbs_pkg::SRC_DATA: bit_val = data_r[cmd.idx];
      cpbs_pkg::SRC_SUM:  bit_val = sum_r[cmd.idx];
      default:            bit_val = 1'b0;
    endcase
  end

  always_comb begin
    data_nxt     = data_r;
    sum_nxt      = sum_r;
    shift_nxt    = shift_r;
    count_nxt    = count_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && out_stall;

    if (cmd.load) begin
      data_nxt = in_word.data_byte;
      sum_nxt  = (in_word.first ? 8'd0 : sum_r) + in_word.data_byte;
    end

    if (cmd.push) begin
      if (count_r == 3'd7) begin
        shift_nxt    = '0;
        count_nxt    = '0;
        held_nxt     = joined;
        held_vld_nxt = 1'b1;
        if (held_vld_r) begin
          out_nxt.out_byte = held_r;
          out_nxt.run_end  = 1'b0;
          out_vld_nxt      = 1'b1;
        end
      end else begin
        shift_nxt = joined[6:0];
        count_nxt = count_r + 3'd1;
      end
    end

    if (cmd.flush && held_vld_r && out_free) begin
      out_nxt.out_byte = held_r;
      out_nxt.run_end  = 1'b1;
      out_vld_nxt      = 1'b1;
      held_vld_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    held_r  <= held_nxt;
    out_r   <= out_nxt;
    if (!rst_n) begin
      sum_r      <= '0;
      shift_r    <= '0;
      count_r    <= '0;
      held_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      sum_r      <= sum_nxt;
      shift_r    <= shift_nxt;
      count_r    <= count_nxt;
      held_vld_r <= held_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign st.push_ok    = !held_vld_r || out_free;
  assign st.flush_done = !held_vld_r || out_free;
  assign st.held_valid = held_vld_r;
  assign out_valid     = out_vld_r;
  assign out_word      = out_r;

endmodule

>>> rtl/cpbs_ctrl.sv
module cpbs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  cpbs_pkg::in_word_t in_word,
  input  cpbs_pkg::status_t  st,
  output cpbs_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_ONE,
    S_HDR_ZERO,
    S_TAIL,
    S_DATA,
    S_SUM,
    S_ZERO,
    S_FLUSH
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] groups_r, groups_nxt;
  logic [4:0] grp_r,    grp_nxt;
  logic [3:0] cnt_r,    cnt_nxt;
  logic       last_r,   last_nxt;
  logic [4:0] grp_init;

  assign grp_init = (groups_r > cpbs_pkg::SyncGroupsMax) ? cpbs_pkg::SyncGroupsMax : groups_r;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    groups_nxt = cfg_wr_en ? cfg_wr_data : groups_r;
    grp_nxt    = grp_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    cmd.load   = 1'b0;
    cmd.push   = 1'b0;
    cmd.src    = cpbs_pkg::SRC_ZERO;
    cmd.idx    = cnt_r[2:0];
    cmd.flush  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          last_nxt = in_word.last;
          if (!in_word.first) begin
            state_nxt = S_DATA;
            cnt_nxt   = cpbs_pkg::ByteBitLast;
          end else if (grp_init != 5'd0) begin
            state_nxt = S_HDR_ONE;
            grp_nxt   = grp_init;
          end else begin
            state_nxt = S_TAIL;
            cnt_nxt   = cpbs_pkg::SyncTailLast;
          end
        end
      end
      S_HDR_ONE: begin
        cmd.src  = cpbs_pkg::SRC_ONE;
        cmd.push = st.push_ok;
        if (st.push_ok) begin
          state_nxt = S_HDR_ZERO;
          cnt_nxt   = cpbs_pkg::ZeroRunLast;
        end
      end
      S_HDR_ZERO: begin
        cmd.src  = cpbs_pkg::SRC_ZERO;
        cmd.push = st.push_ok;
        if (st.push_ok) begin
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_r == 4'd0) begin
            grp_nxt = grp_r - 5'd1;
            if (grp_r == 5'd1) begin
              state_nxt = S_TAIL;
              cnt_nxt   = cpbs_pkg::SyncTailLast;
            end else begin
              state_nxt = S_HDR_ONE;
            end
          end
        end
      end
      S_TAIL: begin
        cmd.src  = cpbs_pkg::SRC_TAIL;
        cmd.push = st.push_ok;
        if (st.push_ok) begin
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_r == 4'd0) begin
            state_nxt = S_DATA;
            cnt_nxt   = cpbs_pkg::ByteBitLast;
          end
        end
      end
      S_DATA: begin
        cmd.src  = cpbs_pkg::SRC_DATA;
        cmd.push = st.push_ok;
        if (st.push_ok) begin
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_r == 4'd0) begin
            state_nxt = last_r ? S_SUM : S_FLUSH;
            cnt_nxt   = cpbs_pkg::ByteBitLast;
          end
        end
      end
      S_SUM: begin
        cmd.src  = cpbs_pkg::SRC_SUM;
        cmd.push = st.push_ok;
        if (st.push_ok) begin
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_r == 4'd0) begin
            state_nxt = S_ZERO;
            cnt_nxt   = cpbs_pkg::ByteBitLast;
          end
        end
      end
      S_ZERO: begin
        cmd.src  = cpbs_pkg::SRC_ZERO;
        cmd.push = st.push_ok;
        if (st.push_ok) begin
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_r == 4'd0) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (st.flush_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    grp_r  <= grp_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      groups_r <= cpbs_pkg::SyncGroupsRst;
    end else begin
      state_r  <= state_nxt;
      groups_r <= groups_nxt;
    end
  end

endmodule

>>> rtl/cassette_packet_bit_serializer_unit.sv
// Packs payload words into a cassette bitstream, eight stream bits per output word.
// Input channel in_valid/in_stall/in_word: one payload byte with first and last marks.
// A first word is preceded by the sync header (cfg groups of a one and sixteen zeros,
// then 1110011) and restarts the checksum; a last word is followed by the checksum
// and eight zero bits. Output channel out_valid/out_stall/out_word carries each
// completed stream byte, earliest bit in the MSB; run_end marks the final byte an
// input word causes. Bits short of a full byte stay pending for the next word.
// Config: cfg_wr_en/cfg_wr_data set the group count (above sixteen saturates to sixteen).
// Throughput: one stream bit per cycle from a single shifter, unless the output stalls;
// a new word is taken only after the previous one has been serialized and flushed.
// in_stall is high while a word is being serialized. A stalled output holds its word;
// the shifter waits while one completed byte is already held behind it.
// Synchronous reset clears the pending bits, checksum, output and sets groups to 13.
module cassette_packet_bit_serializer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  cpbs_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output cpbs_pkg::out_word_t out_word
);

  cpbs_pkg::cmd_t    cmd;
  cpbs_pkg::status_t st;

  cpbs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .st          (st),
    .cmd         (cmd)
  );

  cpbs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !st.held_valid)
    else $error("held byte left over while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted word did not start serializing");

  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> st.push_ok)
    else $error("bit pushed while held byte cannot move");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.push && !cmd.flush)
    else $error("load overlaps shift or flush");
`endif

endmodule

>>> sim/cpbs_checker.sv
`timescale 1ns / 1ps
module cpbs_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  cpbs_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  cpbs_pkg::out_word_t out_word,
  output int                  fail_count,
  output int                  awaited
);

  cpbs_pkg::out_word_t bytes_due[$];
  logic [4:0] sync_groups;
  logic [7:0] shift_acc;
  int         shift_len;
  logic [7:0] running_sum;

  task automatic shift_in_bit(logic b);
    cpbs_pkg::out_word_t w;
    shift_acc = {shift_acc[6:0], b};
    shift_len++;
    if (shift_len == 8) begin
      w.out_byte = shift_acc;
      w.run_end  = 1'b0;
      bytes_due.push_back(w);
      shift_acc = '0;
      shift_len = 0;
    end
  endtask

  task automatic shift_in_byte(logic [7:0] v);
    for (int i = 7; i >= 0; i--) shift_in_bit(v[i]);
  endtask

  task automatic serialize_word(cpbs_pkg::in_word_t w);
    int                  groups;
    int                  queued_prior;
    cpbs_pkg::out_word_t tail;
    queued_prior = bytes_due.size();
    groups = (sync_groups > cpbs_pkg::SyncGroupsMax) ? cpbs_pkg::SyncGroupsMax : sync_groups;
    if (w.first) begin
      for (int g = 0; g < groups; g++) begin
        shift_in_bit(1'b1);
        for (int k = 0; k < cpbs_pkg::SyncZeroRun; k++) shift_in_bit(1'b0);
      end
      for (int k = 6; k >= 0; k--) shift_in_bit(cpbs_pkg::SyncTail[k]);
      running_sum = '0;
    end
    running_sum = running_sum + w.data_byte;
    shift_in_byte(w.data_byte);
    if (w.last) begin
      shift_in_byte(running_sum);
      shift_in_byte(8'h00);
    end
    // mark the final byte of this word
    if (bytes_due.size() > queued_prior) begin
      tail = bytes_due.pop_back();
      tail.run_end = 1'b1;
      bytes_due.push_back(tail);
    end
  endtask

  task automatic check_byte(cpbs_pkg::out_word_t got);
    cpbs_pkg::out_word_t want;
    if (bytes_due.size() == 0) begin
      if (fail_count < 10)
        $display("mismatch at %0t: unexpected word byte %02h run_end %0b",
                 $realtime, got.out_byte, got.run_end);
      fail_count++;
    end else begin
      want = bytes_due.pop_front();
      if (got !== want) begin
        if (fail_count < 10)
          $display("mismatch at %0t: byte exp %02h got %02h, run_end exp %0b got %0b",
                   $realtime, want.out_byte, got.out_byte, want.run_end, got.run_end);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bytes_due.delete();
      sync_groups = cpbs_pkg::SyncGroupsRst;
      shift_acc   = '0;
      shift_len   = 0;
      running_sum = '0;
      fail_count  = 0;
    end else begin
      if (cfg_wr_en) sync_groups = cfg_wr_data;
      if (in_valid && !in_stall) serialize_word(in_word);
      if (out_valid && !out_stall) check_byte(out_word);
    end
    awaited = bytes_due.size();
  end

endmodule

>>> sim/cassette_packet_bit_serializer_unit_test.sv
`timescale 1ns / 1ps
module cassette_packet_bit_serializer_unit_test;

  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 20;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_wr_en   = 1'b0;
  logic [4:0]          cfg_wr_data = '0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  cpbs_pkg::in_word_t  in_word     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  cpbs_pkg::out_word_t out_word;
  int                  fail_count;
  int                  awaited;
  bit                  calm         = 1'b0;
  bit                  hold_request = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cassette_packet_bit_serializer_unit uut (
    .clk,
    .rst_n,
    .cfg_wr_en,
    .cfg_wr_data,
    .in_valid,
    .in_stall,
    .in_word,
    .out_valid,
    .out_stall,
    .out_word
  );

  cpbs_checker chk (
    .clk,
    .rst_n,
    .cfg_wr_en,
    .cfg_wr_data,
    .in_valid,
    .in_stall,
    .in_word,
    .out_valid,
    .out_stall,
    .out_word,
    .fail_count,
    .awaited
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic [7:0] d, logic f, logic l);
    cpbs_pkg::in_word_t w;
    int                 gap;
    w.data_byte = d;
    w.first     = f;
    w.last      = l;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_packet(int len);
    for (int i = 0; i < len; i++)
      send_word(8'($urandom_range(0, 255)), i == 0, i == len - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_groups(logic [4:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(int items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        len = $urandom_range(1, 6);
        send_packet(len);
        sent += len;
      end else begin
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h80, 1'b0, 1'b1);
    send_word(8'hA5, 1'b1, 1'b1);
    send_word(8'h5A, 1'b0, 1'b0);
    send_word(8'h01, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    send_word(8'h7F, 1'b0, 1'b0);

    set_groups(5'd0);
    send_word(8'h3C, 1'b1, 1'b0);
    send_word(8'hC3, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);

    set_groups(5'd31);
    send_word(8'h96, 1'b1, 1'b1);

    set_groups(5'd16);
    send_word(8'h69, 1'b1, 1'b0);
    send_word(8'h12, 1'b0, 1'b1);

    set_groups(5'd17);
    send_word(8'hE7, 1'b1, 1'b1);

    set_groups(5'd1);
    calm = 1'b1;
    random_phase(20);
    calm = 1'b0;
    random_phase(15);

    set_groups(5'd2);
    calm         = 1'b1;
    hold_request = 1'b1;
    random_phase(15);
    calm = 1'b0;
    wait_drained();
    random_phase(15);

    set_groups(5'($urandom_range(0, 5)));
    random_phase(20);

    set_groups(5'd3);
    random_phase(15);

    wait_drained();
    if (fail_count == 0 && awaited == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
